// ===== rtl/hmv_pkg.sv =====
package hmv_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 4096;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int HQ_W        = 19;

    localparam logic [16:0] Q16_ONE = 17'h10000;

    // floor(x / 50) == (x * ceil(2^30 / 50)) >> 30 for every x below 2^24
    localparam logic [24:0] HQ_RECIP = 25'd21474837;
    localparam int          HQ_SHIFT = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_COLUMNS = 3'd0,
        CFG_NUM_ROWS    = 3'd1,
        CFG_SPACING_X   = 3'd2,
        CFG_SPACING_Z   = 3'd3,
        CFG_U_STEP      = 3'd4,
        CFG_V_STEP      = 3'd5
    } cfg_index_t;

    // grid sizes already clamped, stored as last index
    typedef struct packed {
        logic [COL_W-1:0] cols_last;
        logic [ROW_W-1:0] rows_last;
        logic [7:0]       spacing_x;
        logic [7:0]       spacing_z;
        logic [16:0]      u_step;
        logic [16:0]      v_step;
    } cfg_t;

    // one classified sample on its way from front to back
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] pz_count;
        logic [7:0]       height;
        logic [7:0]       left_height;
        logic [7:0]       up_height;
        logic             interior;
        logic             last_vertex;
    } desc_t;

    // height / 50 in Q16, rounded to nearest
    function automatic logic [HQ_W-1:0] height_q16(input logic [7:0] h);
        logic [23:0] x;
        logic [48:0] prod;
        x    = {h, 16'd0} + 24'd25;
        prod = 49'(x) * 49'(HQ_RECIP);
        return prod[HQ_SHIFT +: HQ_W];
    endfunction

endpackage

// ===== rtl/hmv_ifs.sv =====
interface hmv_sample_if;
    logic       valid;
    logic       ready;
    logic [7:0] height_byte;

    modport source (output valid, output height_byte, input ready);
    modport sink   (input valid, input height_byte, output ready);
endinterface

interface hmv_vertex_if;
    logic               valid;
    logic               ready;
    logic [17:0]        pos_x;
    logic [18:0]        pos_y;
    logic [19:0]        pos_z;
    logic signed [27:0] normal_x;
    logic [31:0]        normal_y;
    logic signed [27:0] normal_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               last_vertex;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output normal_x, output normal_y, output normal_z,
                    output tex_u, output tex_v, output last_vertex, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input normal_x, input normal_y, input normal_z,
                    input tex_u, input tex_v, input last_vertex, output ready);
endinterface

interface hmv_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hmv_pkg::CFG_IDX_W-1:0]    index;
    logic [hmv_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/hmv_front.sv =====
module hmv_front (
    input  logic           clk,
    input  logic           rst_n,
    input  hmv_pkg::cfg_t  cfg_view,
    hmv_sample_if.sink     sample,
    output logic           q_push,
    output hmv_pkg::desc_t q_data,
    input  logic           q_full
);
    import hmv_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [7:0]       left_reg, left_next;
    logic             st_valid_reg, st_valid_next;
    desc_t            st_reg;
    logic [7:0]       up_rd_reg;
    logic [7:0]       line_mem [MAX_COLUMNS];

    logic             accept;
    logic             end_row;
    logic             end_grid;
    logic [ROW_W-1:0] pz_count;

    assign sample.ready = !st_valid_reg || !q_full;
    assign accept       = sample.valid && sample.ready;
    assign q_push       = st_valid_reg && !q_full;

    assign end_row  = col_reg >= cfg_view.cols_last;
    assign end_grid = end_row && (row_reg >= cfg_view.rows_last);
    assign pz_count = (row_reg < cfg_view.rows_last) ? cfg_view.rows_last - row_reg : '0;

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        left_next     = left_reg;
        st_valid_next = st_valid_reg;
        if (q_push)
        begin
            st_valid_next = 1'b0;
        end
        if (accept)
        begin
            st_valid_next = 1'b1;
            left_next     = sample.height_byte;
            if (end_grid)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (end_row)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            st_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            left_reg     <= left_next;
            st_valid_reg <= st_valid_next;
        end
    end

    // line buffer: old entry read out, new height written, same slot
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg         <= line_mem[col_reg];
            line_mem[col_reg] <= sample.height_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg.col         <= col_reg;
            st_reg.row         <= row_reg;
            st_reg.pz_count    <= pz_count;
            st_reg.height      <= sample.height_byte;
            st_reg.left_height <= left_reg;
            st_reg.up_height   <= '0;
            st_reg.interior    <= (col_reg != '0) && (row_reg != '0);
            st_reg.last_vertex <= end_grid;
        end
    end

    always_comb
    begin
        q_data           = st_reg;
        q_data.up_height = up_rd_reg;
    end

    a_grid_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_grid |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not return to zero after last vertex");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !end_row |=> col_reg == $past(col_reg) + 1'b1)
        else $error("column counter did not advance");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid_reg && !q_push |=> st_valid_reg && $stable(st_reg))
        else $error("staged sample changed while waiting for the queue");

endmodule

// ===== rtl/hmv_queue.sv =====
module hmv_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hmv_pkg::desc_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output hmv_pkg::desc_t pop_data
);
    import hmv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("pop from empty queue");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/hmv_back.sv =====
module hmv_back (
    input  logic           clk,
    input  logic           rst_n,
    input  hmv_pkg::cfg_t  cfg_view,
    input  logic           q_valid,
    input  hmv_pkg::desc_t q_data,
    output logic           q_pop,
    hmv_vertex_if.source   vertex
);
    import hmv_pkg::*;

    typedef struct packed {
        logic [HQ_W-1:0] hq;
        logic [HQ_W-1:0] lq;
        logic [HQ_W-1:0] uq;
        logic [17:0]     pos_x;
        logic [19:0]     pos_z;
        logic [16:0]     tex_u;
        logic [16:0]     tex_v;
        logic [15:0]     sxsz;
        logic            interior;
        logic            last_vertex;
    } mid_t;

    typedef struct packed {
        logic [17:0]        pos_x;
        logic [18:0]        pos_y;
        logic [19:0]        pos_z;
        logic signed [27:0] normal_x;
        logic [31:0]        normal_y;
        logic signed [27:0] normal_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic               last_vertex;
    } vtx_t;

    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    mid_t s1_reg, s1_in;
    vtx_t out_reg, out_in;

    logic out_load;
    logic s1_move;
    logic s1_load;

    logic [26:0]        tu_raw;
    logic [28:0]        tv_raw;
    logic signed [19:0] dyl;
    logic signed [19:0] dyu;
    logic signed [8:0]  sx_s;
    logic signed [8:0]  sz_s;
    logic signed [28:0] nx_full;
    logic signed [28:0] nz_prod;

    // stage handshake: everything moves when the output slot frees up
    assign out_load = !out_valid_reg || vertex.ready;
    assign s1_move  = s1_valid_reg && out_load;
    assign s1_load  = !s1_valid_reg || s1_move;
    assign q_pop    = q_valid && s1_load;

    // stage 1: height scaling and the position / texture products
    always_comb
    begin
        tu_raw            = 27'(q_data.col) * 27'(cfg_view.u_step);
        tv_raw            = 29'(q_data.row) * 29'(cfg_view.v_step);
        s1_in.hq          = height_q16(q_data.height);
        s1_in.lq          = height_q16(q_data.left_height);
        s1_in.uq          = height_q16(q_data.up_height);
        s1_in.pos_x       = 18'(q_data.col) * 18'(cfg_view.spacing_x);
        s1_in.pos_z       = 20'(q_data.pz_count) * 20'(cfg_view.spacing_z);
        s1_in.tex_u       = (tu_raw > 27'(Q16_ONE)) ? Q16_ONE : tu_raw[16:0];
        s1_in.tex_v       = (tv_raw > 29'(Q16_ONE)) ? Q16_ONE : tv_raw[16:0];
        s1_in.sxsz        = 16'(cfg_view.spacing_x) * 16'(cfg_view.spacing_z);
        s1_in.interior    = q_data.interior;
        s1_in.last_vertex = q_data.last_vertex;
    end

    // stage 2: height differences and normal products
    always_comb
    begin
        sx_s    = $signed({1'b0, cfg_view.spacing_x});
        sz_s    = $signed({1'b0, cfg_view.spacing_z});
        dyl     = $signed({1'b0, s1_reg.lq}) - $signed({1'b0, s1_reg.hq});
        dyu     = $signed({1'b0, s1_reg.uq}) - $signed({1'b0, s1_reg.hq});
        nx_full = dyl * sz_s;
        nz_prod = dyu * sx_s;

        out_in.pos_x       = s1_reg.pos_x;
        out_in.pos_y       = s1_reg.hq;
        out_in.pos_z       = s1_reg.pos_z;
        out_in.tex_u       = s1_reg.tex_u;
        out_in.tex_v       = s1_reg.tex_v;
        out_in.last_vertex = s1_reg.last_vertex;
        if (s1_reg.interior)
        begin
            out_in.normal_x = nx_full[27:0];
            out_in.normal_y = {s1_reg.sxsz, 16'd0};
            out_in.normal_z = 28'(-nz_prod);
        end
        else
        begin
            out_in.normal_x = '0;
            out_in.normal_y = 32'(Q16_ONE);
            out_in.normal_z = '0;
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = q_valid;
        end
        if (out_load)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_reg <= s1_in;
        end
        if (s1_move)
        begin
            out_reg <= out_in;
        end
    end

    assign vertex.valid       = out_valid_reg;
    assign vertex.pos_x       = out_reg.pos_x;
    assign vertex.pos_y       = out_reg.pos_y;
    assign vertex.pos_z       = out_reg.pos_z;
    assign vertex.normal_x    = out_reg.normal_x;
    assign vertex.normal_y    = out_reg.normal_y;
    assign vertex.normal_z    = out_reg.normal_z;
    assign vertex.tex_u       = out_reg.tex_u;
    assign vertex.tex_v       = out_reg.tex_v;
    assign vertex.last_vertex = out_reg.last_vertex;

endmodule

// ===== rtl/heightmap_grid_vertex_generator.sv =====
// Heightmap grid vertex generator: takes one height byte per transaction in raster
// order and returns one terrain vertex per transaction (position, unnormalized Q16
// normal, Q16 texture coordinates, and a flag on the grid's last vertex). Sustained
// rate is one vertex per clock unless the vertex output stalls; a sample passes the
// line buffer read stage, one queue slot and two arithmetic stages. The line buffer
// is a 1024 x 8 memory with one read and one write per cycle at the same column slot;
// its entries are not cleared after reset, so the first row reads unwritten entries;
// only interior normals, from the second row on, use them. Grid size registers are
// clamped to 2..1024 columns and 2..4096 rows. Configuration may be written only while
// no transaction is in flight; the configuration channel is always ready.
module heightmap_grid_vertex_generator (
    input  logic         clk,
    input  logic         rst_n,
    hmv_cfg_if.sink      cfg,
    hmv_sample_if.sink   sample,
    hmv_vertex_if.source vertex
);
    import hmv_pkg::*;

    // configuration registers, reset to the values in the register list
    logic [10:0] num_columns_reg;
    logic [12:0] num_rows_reg;
    logic [7:0]  spacing_x_reg;
    logic [7:0]  spacing_z_reg;
    logic [16:0] u_step_reg;
    logic [16:0] v_step_reg;

    cfg_t  cfg_view;
    logic  cfg_write;

    // front-to-back queue signals
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    desc_t q_in;
    desc_t q_out;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_columns_reg <= 11'd2;
            num_rows_reg    <= 13'd2;
            spacing_x_reg   <= 8'd1;
            spacing_z_reg   <= 8'd1;
            u_step_reg      <= Q16_ONE;
            v_step_reg      <= Q16_ONE;
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                CFG_NUM_COLUMNS: num_columns_reg <= cfg.data[10:0];
                CFG_NUM_ROWS:    num_rows_reg    <= cfg.data[12:0];
                CFG_SPACING_X:   spacing_x_reg   <= cfg.data[7:0];
                CFG_SPACING_Z:   spacing_z_reg   <= cfg.data[7:0];
                CFG_U_STEP:      u_step_reg      <= cfg.data[16:0];
                CFG_V_STEP:      v_step_reg      <= cfg.data[16:0];
                default:         ; // unused register slots are ignored
            endcase
        end
    end

    // clamp grid size and keep it as last valid index
    always_comb
    begin
        if (num_columns_reg < 11'd2)
            cfg_view.cols_last = COL_W'(1);
        else if (num_columns_reg > 11'(MAX_COLUMNS))
            cfg_view.cols_last = COL_W'(MAX_COLUMNS - 1);
        else
            cfg_view.cols_last = COL_W'(num_columns_reg - 11'd1);

        if (num_rows_reg < 13'd2)
            cfg_view.rows_last = ROW_W'(1);
        else if (num_rows_reg > 13'(MAX_ROWS))
            cfg_view.rows_last = ROW_W'(MAX_ROWS - 1);
        else
            cfg_view.rows_last = ROW_W'(num_rows_reg - 13'd1);

        cfg_view.spacing_x = spacing_x_reg;
        cfg_view.spacing_z = spacing_z_reg;
        cfg_view.u_step    = u_step_reg;
        cfg_view.v_step    = v_step_reg;
    end

    // front: grid counters, neighbor heights, line buffer
    hmv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_view (cfg_view),
        .sample   (sample),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    // short queue so front and back stall independently
    hmv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    // back: Q16 heights, products, output register
    hmv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_view (cfg_view),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .vertex   (vertex)
    );

endmodule
